@@ hdl/bfpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfpa_pkg
// types and constants shared by the best-fit page allocator modules
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam int unsigned CNT_W  = 21;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned PAGE_W = 36;
    localparam int unsigned MAXR_W = 21;
    localparam int unsigned MINR_W = 17;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_MAXR = 2'd1;
    localparam logic [1:0] CFG_MINR = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REGION = 2'd1;
    localparam logic [1:0] ST_BIG    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic              func;
        logic [LEN_W-1:0]  length_bytes;
        logic [PAGE_W-1:0] block_page;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0] result_page;
        logic [1:0]        status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GROW,
        S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic grow;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic grow_done;
        logic need_grow;
    } t_status;

endpackage

@@ hdl/bfpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfpa_ctrl
// sequencer: load, table scan, region sizing, commit, result hold
// ----------------------------------------------------------------------------
module bfpa_ctrl
    import bfpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if (!i_sts.need_grow || i_sts.grow_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.grow = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_OUT))
        else $error("commit not followed by result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("accept while result pending");
    a_scan_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.scan)
        else $error("scan did not start");
`endif

endmodule

@@ hdl/bfpa_dp.sv @@
// ----------------------------------------------------------------------------
// bfpa_dp
// free-block table, best-fit scan, region sizing and result register
// ----------------------------------------------------------------------------
module bfpa_dp
    import bfpa_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES  = 64,
    parameter int unsigned PAGE_BITS      = 12,
    parameter int unsigned ADDR_PAGE_BITS = 36
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_in_item          i_item,
    input  logic [PAGE_W-1:0] i_base,
    input  logic [MAXR_W-1:0] i_maxr,
    input  logic [MINR_W-1:0] i_minr,
    output t_status           o_sts,
    output t_out_item         o_item
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned PW = LEN_W - PAGE_BITS + 1;
    localparam int unsigned CW = (PW > CNT_W) ? PW : CNT_W;
    localparam logic [ADDR_PAGE_BITS-1:0] AMASK = '1;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]        r_start [TABLE_ENTRIES];
    logic [CNT_W-1:0]         r_count [TABLE_ENTRIES];

    logic              r_func;
    logic [PAGE_W-1:0] r_blk;
    logic [PW-1:0]     r_pages;
    logic [IW-1:0]     r_idx;
    logic              r_best_ok;
    logic [IW-1:0]     r_best;
    logic [CNT_W-1:0]  r_best_cnt;
    logic [PAGE_W-1:0] r_best_st;
    logic              r_free_ok;
    logic [IW-1:0]     r_free;
    logic [CNT_W:0]    r_size;
    logic              r_grow_done;
    logic [CNT_W-1:0]  r_last;
    logic [PAGE_W-1:0] r_off;
    t_out_item         r_out;

    // registered table read, one entry behind the scan index
    logic              r_pv;
    logic [IW-1:0]     r_pidx;
    logic              r_rd_v;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic [PAGE_W-1:0] r_rd_st;

    logic [PW-1:0]     w_pages;
    logic [PW+PAGE_BITS-1:0] w_sum;
    logic              w_fit, w_better;
    logic [CNT_W:0]    w_size0;
    logic [MINR_W-1:0] w_lo;
    logic              w_grow_more;
    logic [PAGE_W-1:0] w_rstart;

    assign w_sum   = {{(PW+PAGE_BITS-LEN_W){1'b0}}, i_item.length_bytes}
                   + {{PW{1'b0}}, {PAGE_BITS{1'b1}}};
    assign w_pages = w_sum[PW+PAGE_BITS-1:PAGE_BITS];
    assign w_fit   = r_rd_v && (CW'(r_pages) <= CW'(r_rd_cnt));
    assign w_better = !r_best_ok || (r_rd_cnt < r_best_cnt)
                   || (r_rd_cnt == r_best_cnt && r_rd_st < r_best_st);
    assign w_lo    = (i_minr == '0) ? MINR_W'(1) : i_minr;
    assign w_size0 = ({r_last, 1'b0} < {{(CNT_W+1-MINR_W){1'b0}}, w_lo})
                   ? {{(CNT_W+1-MINR_W){1'b0}}, w_lo} : {r_last, 1'b0};
    assign w_grow_more = ({{(CNT_W+1 > PW ? CNT_W+1-PW : 0){1'b0}}, r_pages} > r_size)
                   && (r_size < {1'b0, i_maxr});
    assign w_rstart = (i_base + r_off) & PAGE_W'(AMASK);

    logic w_is_alloc_miss;
    logic w_big;
    assign w_big = {{(CNT_W+1 > PW ? CNT_W+1-PW : 0){1'b0}}, r_pages} > {1'b0, i_maxr};
    assign w_is_alloc_miss = (r_func == FUNC_ALLOC) && (r_pages != '0) && !r_best_ok && !w_big;

    assign o_sts.scan_last = r_pv && (r_pidx == IW'(TABLE_ENTRIES-1));
    assign o_sts.need_grow = w_is_alloc_miss;
    assign o_sts.grow_done = r_grow_done;
    assign o_item = r_out;

    logic [CNT_W:0] w_fsize;
    assign w_fsize = (r_size > {1'b0, i_maxr}) ? {1'b0, i_maxr} : r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_last  <= '0;
            r_off   <= '0;
        end else if (i_cmd.commit) begin
            if (r_pages == '0) begin
                r_out.result_page <= '0;
                r_out.status      <= ST_OK;
            end else if (r_func == FUNC_FREE) begin
                r_out.result_page <= '0;
                if (r_pages > PW'({CNT_W{1'b1}})) begin
                    r_out.status <= ST_BIG;
                end else if (!r_free_ok) begin
                    r_out.status <= ST_FULL;
                end else begin
                    r_out.status    <= ST_OK;
                    r_valid[r_free] <= 1'b1;
                    r_start[r_free] <= r_blk;
                    r_count[r_free] <= CNT_W'(r_pages);
                end
            end else if (r_best_ok) begin
                r_out.result_page <= r_best_st;
                r_out.status      <= ST_OK;
                r_start[r_best]   <= (r_best_st + PAGE_W'(r_pages)) & PAGE_W'(AMASK);
                r_count[r_best]   <= r_best_cnt - CNT_W'(r_pages);
                if (r_best_cnt == CNT_W'(r_pages)) begin
                    r_valid[r_best] <= 1'b0;
                end
            end else if (w_big) begin
                r_out.result_page <= '0;
                r_out.status      <= ST_BIG;
            end else if ((w_fsize > {{(CNT_W+1 > PW ? CNT_W+1-PW : 0){1'b0}}, r_pages})
                         && !r_free_ok) begin
                r_out.result_page <= '0;
                r_out.status      <= ST_FULL;
            end else begin
                if (w_fsize > {{(CNT_W+1 > PW ? CNT_W+1-PW : 0){1'b0}}, r_pages}) begin
                    r_valid[r_free] <= 1'b1;
                    r_start[r_free] <= (w_rstart + PAGE_W'(r_pages)) & PAGE_W'(AMASK);
                    r_count[r_free] <= CNT_W'(w_fsize - (CNT_W+1)'(r_pages));
                end
                r_last            <= CNT_W'(w_fsize);
                r_off             <= (r_off + PAGE_W'(w_fsize)) & PAGE_W'(AMASK);
                r_out.result_page <= w_rstart;
                r_out.status      <= ST_REGION;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_item.func;
            r_blk       <= i_item.block_page & PAGE_W'(AMASK);
            r_pages     <= w_pages;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_best_ok   <= 1'b0;
            r_best      <= '0;
            r_best_cnt  <= '0;
            r_best_st   <= '0;
            r_free_ok   <= 1'b0;
            r_free      <= '0;
            r_grow_done <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_v   <= r_valid[r_idx];
            r_rd_cnt <= r_count[r_idx];
            r_rd_st  <= r_start[r_idx];
            r_pidx   <= r_idx;
            r_pv     <= 1'b1;
            if (r_pv && w_fit && w_better) begin
                r_best_ok  <= 1'b1;
                r_best     <= r_pidx;
                r_best_cnt <= r_rd_cnt;
                r_best_st  <= r_rd_st;
            end
            if (!r_valid[r_idx] && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_idx;
            end
            if (r_idx != IW'(TABLE_ENTRIES-1)) begin
                r_idx <= r_idx + IW'(1);
            end
            r_size <= w_size0;
        end else if (i_cmd.grow) begin
            if (w_grow_more) begin
                r_size <= {r_size[CNT_W-1:0], 1'b0};
            end else begin
                r_grow_done <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_best_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_best_ok) |-> r_valid[r_best])
        else $error("best entry not valid");
    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_free_ok) |-> !r_valid[r_free])
        else $error("free slot occupied");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.scan, i_cmd.grow, i_cmd.commit}))
        else $error("conflicting commands");
`endif

endmodule

@@ hdl/best_fit_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// best_fit_page_allocator_unit
// best-fit page allocator over a table of free blocks with region bump pointer
// ----------------------------------------------------------------------------
// sequence: accept in idle, linear table scan, region sizing for a scan miss that
//   reserves a region (one doubling step at a time), commit, result held until taken
// throughput: a new transaction is taken only after the previous result is taken;
//   the linear table scan does one registered entry read per cycle
// reset: synchronous active low, clears valid bits, bump pointer, last size
// config registers return to base 0, max 65536, min 16
module best_fit_page_allocator_unit
    import bfpa_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES  = 64,
    parameter int unsigned PAGE_BITS      = 12,
    parameter int unsigned ADDR_PAGE_BITS = 36
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // configuration registers
    logic [PAGE_W-1:0] r_base;
    logic [MAXR_W-1:0] r_maxr;
    logic [MINR_W-1:0] r_minr;

    t_cmd    w_cmd;
    t_status w_sts;

    assign o_cfg_ready = 1'b1;

    // config transaction write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_maxr <= MAXR_W'(65536);
            r_minr <= MINR_W'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE: r_base <= i_cfg_data[PAGE_W-1:0];
                CFG_MAXR: r_maxr <= i_cfg_data[MAXR_W-1:0];
                CFG_MINR: r_minr <= i_cfg_data[MINR_W-1:0];
                default:  ;
            endcase
        end
    end

    bfpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    bfpa_dp #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .PAGE_BITS      (PAGE_BITS),
        .ADDR_PAGE_BITS (ADDR_PAGE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_data),
        .i_base  (r_base),
        .i_maxr  (r_maxr),
        .i_minr  (r_minr),
        .o_sts   (w_sts),
        .o_item  (o_out_data)
    );

endmodule

@@ tb/best_fit_page_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// best_fit_page_allocator_unit_tb
// self-checking bench for the best-fit page allocator: a directed table of
// allocate and free transactions, then randomized phases under several
// register settings; typed directed rows are compared with hand-written
// results, every other result with an in-bench free-list model
module best_fit_page_allocator_unit_tb;
    import bfpa_pkg::*;

    localparam int unsigned N_SLOTS    = 64;
    localparam int unsigned PG_SHIFT   = 12;
    localparam logic [63:0] PG_ROUND   = 64'd4095;
    localparam logic [63:0] CNT_LIMIT  = 64'h1F_FFFF;
    localparam int unsigned DRAIN_WAIT = 120;   // scan of all slots plus doubling steps
    localparam int unsigned STALL_HOLD = 600;
    localparam int unsigned IDLE_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    best_fit_page_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // free-list model state: slot table, region bump pointer, registers
    logic        slot_used  [N_SLOTS];
    logic [35:0] slot_start [N_SLOTS];
    logic [63:0] slot_pages [N_SLOTS];
    logic [20:0] prev_region_pages;
    logic [35:0] bump_offset;
    logic [35:0] reg_base;
    logic [20:0] reg_max;
    logic [16:0] reg_min;

    t_out_item pending_results[$];
    int        err_cnt;
    int        idle_cycles;
    int        burst_left;

    // receiver stall control
    bit        hold_req;
    int        hold_left;
    int        stall_mode;
    int        mode_left;
    int        rx_cyc;

    typedef struct {
        logic        func;
        logic [31:0] len;
        logic [35:0] blk;
        bit          typed;
        logic [35:0] page;
        logic [1:0]  st;
    } t_dir_row;

    t_dir_row dir_rows[15];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int first_open_slot();
        for (int i = 0; i < N_SLOTS; i++) begin
            if (!slot_used[i]) return i;
        end
        return -1;
    endfunction

    // allocate or free against the model table, returns the expected result
    task automatic predict_alloc(input t_in_item it, output t_out_item res);
        logic [63:0] pages;
        logic [63:0] size;
        logic [63:0] lo;
        logic [35:0] start;
        int          k;
        int          best;
        bit          full;
        res   = '0;
        pages = ({32'd0, it.length_bytes} + PG_ROUND) >> PG_SHIFT;
        if (it.func == FUNC_FREE) begin
            if (pages != 0) begin
                if (pages > CNT_LIMIT) begin
                    res.status = ST_BIG;
                end else begin
                    k = first_open_slot();
                    if (k < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_used[k]  = 1'b1;
                        slot_start[k] = it.block_page;
                        slot_pages[k] = pages;
                    end
                end
            end
        end else if (pages != 0) begin
            best = -1;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (slot_used[i] && slot_pages[i] >= pages) begin
                    if (best < 0 || slot_pages[i] < slot_pages[best] ||
                        (slot_pages[i] == slot_pages[best] &&
                         slot_start[i] < slot_start[best]))
                        best = i;
                end
            end
            if (best >= 0) begin
                res.result_page   = slot_start[best];
                slot_start[best]  = slot_start[best] + pages[35:0];
                slot_pages[best]  = slot_pages[best] - pages;
                if (slot_pages[best] == 0) slot_used[best] = 1'b0;
            end else if (pages > {43'd0, reg_max}) begin
                res.status = ST_BIG;
            end else begin
                // new region: double the previous size, clamp, grow until it fits
                size  = {43'd0, prev_region_pages} << 1;
                lo    = (reg_min == 0) ? 64'd1 : {47'd0, reg_min};
                start = reg_base + bump_offset;
                k     = -1;
                full  = 1'b0;
                if (size < lo) size = lo;
                while (size < pages && size < {43'd0, reg_max}) size = size << 1;
                if (size > {43'd0, reg_max}) size = {43'd0, reg_max};
                if (size > pages) begin
                    k = first_open_slot();
                    if (k < 0) full = 1'b1;
                end
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    if (k >= 0) begin
                        slot_used[k]  = 1'b1;
                        slot_start[k] = start + pages[35:0];
                        slot_pages[k] = size - pages;
                    end
                    prev_region_pages = size[20:0];
                    bump_offset       = bump_offset + size[35:0];
                    res.result_page   = start;
                    res.status        = ST_REGION;
                end
            end
        end
    endtask

    // one input transaction; bursts of random length with random gaps between
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        int        gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_alloc(it, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // sender pauses until every expected result is back, then lets the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE: reg_base = val[35:0];
            CFG_MAXR: reg_max  = val[20:0];
            CFG_MINR: reg_min  = val[16:0];
            default: ;
        endcase
    endtask

    function automatic logic [35:0] rand_page();
        return {4'($urandom_range(0, 15)), $urandom()};
    endfunction

    // mostly small well-formed requests, some noise with full-range fields
    function automatic t_in_item rand_item(input int max_pg);
        t_in_item it;
        int       pg;
        int       pick;
        pick            = $urandom_range(0, 99);
        pg              = $urandom_range(1, max_pg);
        it.block_page   = rand_page();
        it.length_bytes = (pg - 1) * 4096 + $urandom_range(1, 4096);
        it.func         = (pick < 48) ? FUNC_FREE : FUNC_ALLOC;
        if (pick >= 90) begin
            it.func         = 1'($urandom_range(0, 1));
            it.length_bytes = (pick < 94) ? 32'd0 : $urandom();
        end
        return it;
    endfunction

    task automatic run_random(input int n, input int max_pg);
        for (int i = 0; i < n; i++) send_item(rand_item(max_pg), 1'b0, '0);
    endtask

    // receiver: stall pattern of its own, changing mode now and then,
    // plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cyc++;
            if (hold_req) begin
                hold_left = STALL_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(50, 300);
                end
                mode_left--;
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 2) == 0);
                    2: i_out_stall <= rx_cyc[2];
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result page=%h status=%0d",
                         $time, o_out_data.result_page, o_out_data.status);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_page !== want.result_page) begin
                    $display("%0t: result_page expected %h actual %h",
                             $time, want.result_page, o_out_data.result_page);
                    err_cnt++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out_data.status);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_in_item  it;
        t_out_item typed_res;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= '0;
        err_cnt     = 0;
        idle_cycles = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        mode_left   = 0;
        stall_mode  = 0;
        rx_cyc      = 0;
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_start[i] = '0;
            slot_pages[i] = '0;
        end
        prev_region_pages = '0;
        bump_offset       = '0;
        reg_base          = '0;
        reg_max           = 21'd65536;
        reg_min           = 17'd16;

        // directed rows at reset settings; typed results follow the free list by hand
        dir_rows = '{
            '{FUNC_ALLOC, 32'd0,          36'h0,         1'b1, 36'd0,         ST_OK},
            '{FUNC_FREE,  32'd0,          36'hFFFFFFFFF, 1'b1, 36'd0,         ST_OK},
            '{FUNC_ALLOC, 32'd1,          36'hFFFFFFFFF, 1'b1, 36'd0,         ST_REGION},
            '{FUNC_ALLOC, 32'd4096,       36'h0,         1'b1, 36'd1,         ST_OK},
            '{FUNC_ALLOC, 32'hFFFFFFFF,   36'h0,         1'b1, 36'd0,         ST_BIG},
            '{FUNC_FREE,  32'hFFFFFFFF,   36'hFFFFFFFFF, 1'b1, 36'd0,         ST_OK},
            '{FUNC_ALLOC, 32'hFFFFFFFF,   36'h0,         1'b1, 36'hFFFFFFFFF, ST_OK},
            '{FUNC_FREE,  32'd8192,       36'd100,       1'b1, 36'd0,         ST_OK},
            // equal sizes: lower start page wins
            '{FUNC_FREE,  32'd8192,       36'd50,        1'b1, 36'd0,         ST_OK},
            '{FUNC_ALLOC, 32'd8192,       36'h0,         1'b1, 36'd50,        ST_OK},
            '{FUNC_ALLOC, 32'd5000,       36'h0,         1'b1, 36'd100,       ST_OK},
            '{FUNC_ALLOC, 32'd57344,      36'h0,         1'b1, 36'd2,         ST_OK},
            // no fit: region doubles from the previous one
            '{FUNC_ALLOC, 32'd69632,      36'h0,         1'b1, 36'd16,        ST_REGION},
            '{FUNC_FREE,  32'd1,          36'd7,         1'b0, 36'd0,         ST_OK},
            '{FUNC_ALLOC, 32'd61440,      36'h0,         1'b1, 36'd33,        ST_OK}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            it.func         = dir_rows[r].func;
            it.length_bytes = dir_rows[r].len;
            it.block_page   = dir_rows[r].blk;
            typed_res.result_page = dir_rows[r].page;
            typed_res.status      = dir_rows[r].st;
            send_item(it, dir_rows[r].typed, typed_res);
        end

        // reset settings, long receiver hold-off so the block backs up
        hold_req = 1'b1;
        run_random(150, 20);
        drain();
        run_random(150, 20);
        drain();

        // smallest region sizes, base near the top so the bump pointer wraps
        write_reg(CFG_BASE, 64'hFFFFFFFF0);
        write_reg(CFG_MAXR, 64'd1);
        write_reg(CFG_MINR, 64'd1);
        run_random(100, 3);
        drain();

        // large region sizes; flood with frees to fill the table
        write_reg(CFG_BASE, {28'd0, rand_page()});
        write_reg(CFG_MAXR, 64'd1048576);
        write_reg(CFG_MINR, 64'd65536);
        for (int i = 0; i < 70; i++) begin
            it.func         = FUNC_FREE;
            it.length_bytes = $urandom_range(1, 4096);
            it.block_page   = rand_page();
            send_item(it, 1'b0, '0);
        end
        for (int i = 0; i < 20; i++) begin
            it.func         = FUNC_ALLOC;
            it.length_bytes = (i % 2) ? $urandom_range(1, 4096) : $urandom();
            it.block_page   = rand_page();
            send_item(it, 1'b0, '0);
        end
        run_random(60, 40);
        drain();

        // mid-range settings with more growth steps
        write_reg(CFG_BASE, {28'd0, rand_page()});
        write_reg(CFG_MAXR, 64'd64);
        write_reg(CFG_MINR, 64'd1);
        run_random(200, 70);
        drain();
        run_random(170, 30);
        drain();

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
